FILE: rtl/core/rectangle_grid_test_pattern_defines.svh
// assertion macros for the grid test pattern generator
// no dependencies; included by files that carry assertions
`ifndef RECTANGLE_GRID_TEST_PATTERN_DEFINES_SVH
`define RECTANGLE_GRID_TEST_PATTERN_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RGTP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define RGTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RGTP_ASSERT(label, clk, rst, prop, msg)
`define RGTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rgtp_pkg.sv
// shared types and constants for the grid test pattern generator
// no dependencies
package rgtp_pkg;

  localparam int COORD_W   = 11;
  localparam int COUNT_W   = 8;
  localparam int COLOR_W   = 24;
  localparam int STEP_W    = 8;
  localparam int MODE_W    = 2;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LIN_W     = 16;

  // pattern modes
  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIRECT  = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RECT_COUNT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_COLOR  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_STEP   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

  // register reset values
  localparam logic [COUNT_W-1:0] RECT_COUNT_RST   = 8'd1;
  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 11'd768;

  // parameter defaults
  localparam int INDEX_BITS_DEF   = 8;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int RED_POS_DEF      = 16;
  localparam int GREEN_POS_DEF    = 8;
  localparam int BLUE_POS_DEF     = 0;
  localparam int MID_DEPTH_DEF    = 4;
  localparam int OUT_DEPTH_DEF    = 4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [COORD_W-1:0] rect_w;
    logic [COORD_W-1:0] rect_h;
    logic [COLOR_W-1:0] first;
    logic [STEP_W-1:0]  step;
    logic [COORD_W-1:0] frame_w;
    logic [COORD_W-1:0] frame_h;
  } cfg_t;

  // classified pixel from the scan front end
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COUNT_W-1:0] col;
    logic [COUNT_W-1:0] row;
    logic               we;
    logic               indexed;
    logic               frame_end;
  } pix_rec_t;

  // finished result
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               we;
    logic               frame_end;
  } out_rec_t;

endpackage

FILE: rtl/core/rgtp_fifo.sv
// small first-in first-out queue of registers
// no dependencies
module rgtp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/rgtp_front.sv
// scan front end: raster position, rectangle tracking and pixel classification
// depends on rgtp_pkg
module rgtp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              restart,
  input  rgtp_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              take,
  output rgtp_pkg::pix_rec_t rec
);
  import rgtp_pkg::*;

  logic [COORD_W-1:0] scan_x, scan_x_next;
  logic [COORD_W-1:0] scan_y, scan_y_next;
  logic [COUNT_W-1:0] grid_column, grid_column_next;
  logic [COUNT_W-1:0] grid_row, grid_row_next;
  logic [COORD_W-1:0] offset_x, offset_x_next;
  logic [COORD_W-1:0] offset_y, offset_y_next;

  logic [COORD_W-1:0] cur_x, cur_y, cur_ox, cur_oy;
  logic [COUNT_W-1:0] cur_col, cur_row;
  logic               in_grid, on, last_x, last_y;

  assign take = push && !q_full;

  // classify the current pixel and work out the next scan position
  always_comb begin
    cur_x   = restart ? '0 : scan_x;
    cur_y   = restart ? '0 : scan_y;
    cur_col = restart ? '0 : grid_column;
    cur_row = restart ? '0 : grid_row;
    cur_ox  = restart ? '0 : offset_x;
    cur_oy  = restart ? '0 : offset_y;

    in_grid = (cfg.rect_w != '0) && (cfg.rect_h != '0)
           && (cur_col < cfg.count) && (cur_row < cfg.count);
    on     = (cfg.mode == MODE_INDEXED) || (cfg.mode == MODE_DIRECT);
    last_x = ({1'b0, cur_x} + 12'd1) >= {1'b0, cfg.frame_w};
    last_y = ({1'b0, cur_y} + 12'd1) >= {1'b0, cfg.frame_h};

    rec.x         = cur_x;
    rec.y         = cur_y;
    rec.col       = cur_col;
    rec.row       = cur_row;
    rec.we        = in_grid && on;
    rec.indexed   = (cfg.mode == MODE_INDEXED);
    rec.frame_end = last_x && last_y;

    scan_x_next      = cur_x;
    scan_y_next      = cur_y;
    grid_column_next = cur_col;
    grid_row_next    = cur_row;
    offset_x_next    = cur_ox;
    offset_y_next    = cur_oy;

    if (!last_x) begin
      scan_x_next = cur_x + COORD_W'(1);
      if (({1'b0, cur_ox} + 12'd1) >= {1'b0, cfg.rect_w}) begin
        offset_x_next = '0;
        if (cur_col != '1) begin
          grid_column_next = cur_col + COUNT_W'(1);
        end
      end else begin
        offset_x_next = cur_ox + COORD_W'(1);
      end
    end else begin
      scan_x_next      = '0;
      grid_column_next = '0;
      offset_x_next    = '0;
      if (!last_y) begin
        scan_y_next = cur_y + COORD_W'(1);
        if (({1'b0, cur_oy} + 12'd1) >= {1'b0, cfg.rect_h}) begin
          offset_y_next = '0;
          if (cur_row != '1) begin
            grid_row_next = cur_row + COUNT_W'(1);
          end
        end else begin
          offset_y_next = cur_oy + COORD_W'(1);
        end
      end else begin
        scan_y_next   = '0;
        grid_row_next = '0;
        offset_y_next = '0;
      end
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_x      <= '0;
      scan_y      <= '0;
      grid_column <= '0;
      grid_row    <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
    end else if (take) begin
      scan_x      <= scan_x_next;
      scan_y      <= scan_y_next;
      grid_column <= grid_column_next;
      grid_row    <= grid_row_next;
      offset_x    <= offset_x_next;
      offset_y    <= offset_y_next;
    end
  end

endmodule

FILE: rtl/core/rgtp_back.sv
// color back end: two-stage color pipeline fed from the pixel queue
// depends on rgtp_pkg
module rgtp_back #(
  parameter int INDEX_BITS   = rgtp_pkg::INDEX_BITS_DEF,
  parameter int CHANNEL_BITS = rgtp_pkg::CHANNEL_BITS_DEF,
  parameter int RED_POS      = rgtp_pkg::RED_POS_DEF,
  parameter int GREEN_POS    = rgtp_pkg::GREEN_POS_DEF,
  parameter int BLUE_POS     = rgtp_pkg::BLUE_POS_DEF,
  parameter int OUT_DEPTH    = rgtp_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rgtp_pkg::cfg_t                 cfg,
  input  logic                           q_empty,
  input  rgtp_pkg::pix_rec_t             q_data,
  output logic                           q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output rgtp_pkg::out_rec_t             out_rec
);
  import rgtp_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH+1) + 1;
  localparam logic [COLOR_W-1:0] IDX_MASK =
    COLOR_W'((25'(1) << INDEX_BITS) - 25'(1));

  // stage 1 registers
  logic                    v1;
  pix_rec_t                s1_rec;
  logic [LIN_W-1:0]        s1_lin;
  logic [CHANNEL_BITS-1:0] s1_r_add, s1_g_add, s1_b_add;

  // stage 2 register
  logic                    v2;

  logic [LIN_W-1:0]        lin;
  logic [LIN_W-1:0]        r_prod, g_prod, b_prod;
  logic [COLOR_W-1:0]      idx_color, direct_color, color;
  logic [CHANNEL_BITS-1:0] r_ch, g_ch, b_ch;

  // take a request only when the output queue has room for everything in flight
  assign q_pop = !q_empty
              && (({1'b0, out_count} + CW'(v1) + CW'(v2)) < CW'(OUT_DEPTH));
  assign out_push = v2;

  // stage 1: linear rectangle index and per-channel increments
  always_comb begin
    lin    = (LIN_W'(q_data.row) * LIN_W'(cfg.count)) + LIN_W'(q_data.col);
    r_prod = LIN_W'(q_data.col) * LIN_W'(cfg.step);
    g_prod = LIN_W'(q_data.row) * LIN_W'(cfg.step);
    b_prod = (LIN_W'(q_data.row) + LIN_W'(q_data.col)) * LIN_W'(cfg.step);
  end

  // stage 2: indexed and direct colors
  always_comb begin
    idx_color    = (cfg.first + (COLOR_W'(s1_lin) * COLOR_W'(cfg.step))) & IDX_MASK;
    r_ch         = CHANNEL_BITS'(8'(cfg.first >> RED_POS)) + s1_r_add;
    g_ch         = CHANNEL_BITS'(8'(cfg.first >> GREEN_POS)) + s1_g_add;
    b_ch         = CHANNEL_BITS'(8'(cfg.first >> BLUE_POS)) + s1_b_add;
    direct_color = (COLOR_W'(r_ch) << RED_POS) + (COLOR_W'(g_ch) << GREEN_POS)
                 + (COLOR_W'(b_ch) << BLUE_POS);
    if (!s1_rec.we) begin
      color = '0;
    end else if (s1_rec.indexed) begin
      color = idx_color;
    end else begin
      color = direct_color;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= q_pop;
      v2 <= v1;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    s1_rec   <= q_data;
    s1_lin   <= lin;
    s1_r_add <= CHANNEL_BITS'(r_prod);
    s1_g_add <= CHANNEL_BITS'(g_prod);
    s1_b_add <= CHANNEL_BITS'(b_prod);
    out_rec.x         <= s1_rec.x;
    out_rec.y         <= s1_rec.y;
    out_rec.color     <= color;
    out_rec.we        <= s1_rec.we;
    out_rec.frame_end <= s1_rec.frame_end;
  end

endmodule

FILE: rtl/core/rectangle_grid_test_pattern.sv
// grid test pattern generator: one pixel result per request, raster order
// path: pixel queue, color back end, result queue; a full queue stalls requests
// throughput: otherwise one pixel per cycle, set by front end and color pipeline
// reset clears the scan to pixel 0,0, loads register defaults, empties queues
// depends on rgtp_pkg, rgtp_fifo, rgtp_front, rgtp_back and the defines header
`include "rectangle_grid_test_pattern_defines.svh"
module rectangle_grid_test_pattern #(
  parameter int INDEX_BITS   = rgtp_pkg::INDEX_BITS_DEF,
  parameter int CHANNEL_BITS = rgtp_pkg::CHANNEL_BITS_DEF,
  parameter int RED_POS      = rgtp_pkg::RED_POS_DEF,
  parameter int GREEN_POS    = rgtp_pkg::GREEN_POS_DEF,
  parameter int BLUE_POS     = rgtp_pkg::BLUE_POS_DEF,
  parameter int MID_DEPTH    = rgtp_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH    = rgtp_pkg::OUT_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 restart,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [rgtp_pkg::COORD_W-1:0]         pixel_x,
  output logic [rgtp_pkg::COORD_W-1:0]         pixel_y,
  output logic [rgtp_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                 write_enable,
  output logic                                 frame_end,
  input  logic                                 cfg_write,
  input  logic [rgtp_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [rgtp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rgtp_pkg::*;

  cfg_t                           cfg;
  pix_rec_t                       front_rec;
  pix_rec_t                       mid_rec;
  out_rec_t                       back_rec;
  out_rec_t                       res_rec;
  logic                           front_take;
  logic                           mid_full, mid_empty, mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                           out_push, out_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic [$bits(pix_rec_t)-1:0]    mid_rd;
  logic [$bits(out_rec_t)-1:0]    out_rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_OFF;
      cfg.count   <= RECT_COUNT_RST;
      cfg.rect_w  <= '0;
      cfg.rect_h  <= '0;
      cfg.first   <= '0;
      cfg.step    <= '0;
      cfg.frame_w <= FRAME_WIDTH_RST;
      cfg.frame_h <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_MODE: cfg.mode    <= cfg_data[MODE_W-1:0];
        REG_RECT_COUNT:   cfg.count   <= cfg_data[COUNT_W-1:0];
        REG_RECT_WIDTH:   cfg.rect_w  <= cfg_data[COORD_W-1:0];
        REG_RECT_HEIGHT:  cfg.rect_h  <= cfg_data[COORD_W-1:0];
        REG_FIRST_COLOR:  cfg.first   <= cfg_data[COLOR_W-1:0];
        REG_COLOR_STEP:   cfg.step    <= cfg_data[STEP_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_w <= cfg_data[COORD_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_h <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // scan front end
  rgtp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .restart (restart),
    .cfg     (cfg),
    .q_full  (mid_full),
    .take    (front_take),
    .rec     (front_rec)
  );

  assign full = mid_full;

  // queue between front and back
  rgtp_fifo #(
    .WIDTH ($bits(pix_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_take),
    .wr_data (front_rec),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .full    (mid_full),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  assign mid_rec = pix_rec_t'(mid_rd);

  // color back end
  rgtp_back #(
    .INDEX_BITS   (INDEX_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .RED_POS      (RED_POS),
    .GREEN_POS    (GREEN_POS),
    .BLUE_POS     (BLUE_POS),
    .OUT_DEPTH    (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (mid_empty),
    .q_data    (mid_rec),
    .q_pop     (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_rec   (back_rec)
  );

  // result queue
  rgtp_fifo #(
    .WIDTH ($bits(out_rec_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (back_rec),
    .rd_en   (pop),
    .rd_data (out_rd),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign res_rec      = out_rec_t'(out_rd);
  assign pixel_x      = res_rec.x;
  assign pixel_y      = res_rec.y;
  assign pixel_color  = res_rec.color;
  assign write_enable = res_rec.we;
  assign frame_end    = res_rec.frame_end;

  // checks
  `RGTP_ASSERT(a_out_no_overflow, clk, rst, !(out_push && out_full), "result queue overflow")
  `RGTP_ASSERT(a_mid_no_underflow, clk, rst, !(mid_pop && mid_empty), "pixel queue underflow")
  `RGTP_ASSERT(a_mid_count_bound, clk, rst, mid_count <= MID_DEPTH, "pixel queue count out of range")
  `RGTP_ASSERT_NEXT(a_off_pixel_black, clk, rst, 1'b1, empty || write_enable || (pixel_color == '0), "disabled pixel has a color")

endmodule

FILE: tb/grid_pixel_checker.sv
`timescale 1ns / 1ps
// pixel checker for the grid test pattern generator: tracks register writes,
// predicts one pixel per accepted request and compares every popped result
// depends on rgtp_pkg
module grid_pixel_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic                              full,
  input  logic                              restart,
  input  logic                              empty,
  input  logic                              pop,
  input  logic [rgtp_pkg::COORD_W-1:0]      pixel_x,
  input  logic [rgtp_pkg::COORD_W-1:0]      pixel_y,
  input  logic [rgtp_pkg::COLOR_W-1:0]      pixel_color,
  input  logic                              write_enable,
  input  logic                              frame_end,
  input  logic                              cfg_write,
  input  logic [rgtp_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [rgtp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                error_count,
  output int                                pixels_outstanding
);
  import rgtp_pkg::*;

  localparam logic [COUNT_W-1:0] GRID_INDEX_MAX = 8'd255;
  localparam logic [COLOR_W-1:0] INDEX_MASK     = COLOR_W'((1 << INDEX_BITS_DEF) - 1);
  localparam int                 CHANNEL_MASK   = (1 << CHANNEL_BITS_DEF) - 1;

  cfg_t               grid_cfg;
  logic [COORD_W-1:0] scan_x, scan_y, rect_off_x, rect_off_y;
  logic [COUNT_W-1:0] grid_col, grid_row;
  out_rec_t           expected_pixels[$];
  int                 mismatch_total = 0;

  assign error_count = mismatch_total;

  function automatic void restart_scan();
    scan_x     = '0;
    scan_y     = '0;
    grid_col   = '0;
    grid_row   = '0;
    rect_off_x = '0;
    rect_off_y = '0;
  endfunction

  // color of the rectangle at grid column col, grid row row
  function automatic logic [COLOR_W-1:0] grid_color(int col, int row);
    logic [63:0] idx_sum;
    int          red, green, blue;
    logic [31:0] packed_rgb;
    if (grid_cfg.mode == MODE_INDEXED) begin
      idx_sum = 64'(grid_cfg.first)
              + (64'(row) * 64'(grid_cfg.count) + 64'(col)) * 64'(grid_cfg.step);
      return idx_sum[COLOR_W-1:0] & INDEX_MASK;
    end
    // direct mode: red follows the column, green the row, blue both
    red   = (int'(grid_cfg.first[RED_POS_DEF +: 8]) + col * int'(grid_cfg.step))
            & CHANNEL_MASK;
    green = (int'(grid_cfg.first[GREEN_POS_DEF +: 8]) + row * int'(grid_cfg.step))
            & CHANNEL_MASK;
    blue  = (int'(grid_cfg.first[BLUE_POS_DEF +: 8]) + (row + col) * int'(grid_cfg.step))
            & CHANNEL_MASK;
    packed_rgb = (red << RED_POS_DEF) + (green << GREEN_POS_DEF) + (blue << BLUE_POS_DEF);
    return packed_rgb[COLOR_W-1:0];
  endfunction

  // pixel produced by one tick, then the raster scan moves on
  function automatic out_rec_t next_grid_pixel(logic restart_bit);
    out_rec_t pix;
    logic     in_grid, drawing, last_x, last_y;
    if (restart_bit)
      restart_scan();
    in_grid = grid_cfg.rect_w != '0 && grid_cfg.rect_h != '0
           && grid_col < grid_cfg.count && grid_row < grid_cfg.count;
    drawing = in_grid && (grid_cfg.mode == MODE_INDEXED || grid_cfg.mode == MODE_DIRECT);
    // a zero frame size acts as one, a shrunk frame ends the line at once
    last_x  = {1'b0, scan_x} + 12'd1 >= {1'b0, grid_cfg.frame_w};
    last_y  = {1'b0, scan_y} + 12'd1 >= {1'b0, grid_cfg.frame_h};
    pix.x         = scan_x;
    pix.y         = scan_y;
    pix.color     = drawing ? grid_color(int'(grid_col), int'(grid_row)) : '0;
    pix.we        = drawing;
    pix.frame_end = last_x && last_y;
    if (!last_x) begin
      scan_x = scan_x + 1'b1;
      if ({1'b0, rect_off_x} + 12'd1 >= {1'b0, grid_cfg.rect_w}) begin
        rect_off_x = '0;
        if (grid_col != GRID_INDEX_MAX)
          grid_col = grid_col + 1'b1;
      end else begin
        rect_off_x = rect_off_x + 1'b1;
      end
    end else begin
      scan_x     = '0;
      grid_col   = '0;
      rect_off_x = '0;
      if (!last_y) begin
        scan_y = scan_y + 1'b1;
        if ({1'b0, rect_off_y} + 12'd1 >= {1'b0, grid_cfg.rect_h}) begin
          rect_off_y = '0;
          if (grid_row != GRID_INDEX_MAX)
            grid_row = grid_row + 1'b1;
        end else begin
          rect_off_y = rect_off_y + 1'b1;
        end
      end else begin
        restart_scan();
      end
    end
    return pix;
  endfunction

  function automatic void check_field(string name, logic [COLOR_W-1:0] want,
                                      logic [COLOR_W-1:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      mismatch_total++;
    end
  endfunction

  // compare popped pixels, then predict for the request accepted at this edge
  always @(posedge clk) begin
    out_rec_t want;
    if (rst) begin
      grid_cfg = '{mode: MODE_OFF, count: RECT_COUNT_RST, rect_w: '0, rect_h: '0,
                   first: '0, step: '0, frame_w: FRAME_WIDTH_RST,
                   frame_h: FRAME_HEIGHT_RST};
      restart_scan();
      expected_pixels.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel at x %0d y %0d popped with no request waiting", pixel_x, pixel_y);
          mismatch_total++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", COLOR_W'(want.x), COLOR_W'(pixel_x));
          check_field("pixel_y", COLOR_W'(want.y), COLOR_W'(pixel_y));
          check_field("pixel_color", want.color, pixel_color);
          check_field("write_enable", COLOR_W'(want.we), COLOR_W'(write_enable));
          check_field("frame_end", COLOR_W'(want.frame_end), COLOR_W'(frame_end));
        end
      end
      if (push && !full)
        expected_pixels.push_back(next_grid_pixel(restart));
      // bench must only make register writes while generator idle; unenforced
      if (cfg_write) begin
        case (cfg_index)
          REG_PATTERN_MODE: grid_cfg.mode    = cfg_data[MODE_W-1:0];
          REG_RECT_COUNT:   grid_cfg.count   = cfg_data[COUNT_W-1:0];
          REG_RECT_WIDTH:   grid_cfg.rect_w  = cfg_data[COORD_W-1:0];
          REG_RECT_HEIGHT:  grid_cfg.rect_h  = cfg_data[COORD_W-1:0];
          REG_FIRST_COLOR:  grid_cfg.first   = cfg_data[COLOR_W-1:0];
          REG_COLOR_STEP:   grid_cfg.step    = cfg_data[STEP_W-1:0];
          REG_FRAME_WIDTH:  grid_cfg.frame_w = cfg_data[COORD_W-1:0];
          REG_FRAME_HEIGHT: grid_cfg.frame_h = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
    end
    pixels_outstanding <= expected_pixels.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// bench top for the grid test pattern generator: clock, reset, requests,
// register programming and the verdict
// depends on rgtp_pkg, rectangle_grid_test_pattern and grid_pixel_checker
module testbench;
  import rgtp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam int                PIXEL_TARGET = 950;
  localparam int                HOLD_CYCLES  = 10;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  push         = 1'b0;
  logic                  restart      = 1'b0;
  logic                  pop          = 1'b0;
  logic                  cfg_write    = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  full, empty, write_enable, frame_end;
  logic [COORD_W-1:0]    pixel_x, pixel_y;
  logic [COLOR_W-1:0]    pixel_color;
  int                    error_count, pixels_outstanding;
  int                    push_idle_pct = 0;
  int                    pop_idle_pct  = 0;
  int                    pixels_sent   = 0;

  rectangle_grid_test_pattern u_top (.*);

  grid_pixel_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side stalls at random
  always @(posedge clk)
    pop <= !rst && ($urandom_range(99) >= pop_idle_pct);

  // idling moves from slow receiver to slow sender to none
  task automatic pace_idling();
    if (pixels_sent < PIXEL_TARGET / 3) begin
      push_idle_pct = 25;
      pop_idle_pct <= 60;
    end else if (pixels_sent < 2 * PIXEL_TARGET / 3) begin
      push_idle_pct = 60;
      pop_idle_pct <= 25;
    end else begin
      push_idle_pct = 0;
      pop_idle_pct <= 0;
    end
  endtask

  // one request per pixel tick, with random gaps
  task automatic send_pixels(input int n_pixels, input int restart_pct,
                             input bit lead_restart);
    for (int i = 0; i < n_pixels; i++) begin
      pace_idling();
      while ($urandom_range(99) < push_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push    <= 1'b1;
      restart <= (lead_restart && i == 0) ? 1'b1 : ($urandom_range(99) < restart_pct);
      do @(posedge clk); while (full);
      pixels_sent++;
    end
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pixels_outstanding != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // program every register, send the requests, then wait for all pixels
  task automatic run_phase(input int mode, input int rect_count, input int rect_w,
                           input int rect_h, input int first, input int step,
                           input int frame_w, input int frame_h, input int n_pixels,
                           input int restart_pct, input bit lead_restart);
    write_reg(REG_PATTERN_MODE, mode);
    write_reg(REG_RECT_COUNT, rect_count);
    write_reg(REG_RECT_WIDTH, rect_w);
    write_reg(REG_RECT_HEIGHT, rect_h);
    write_reg(REG_FIRST_COLOR, first);
    write_reg(REG_COLOR_STEP, step);
    write_reg(REG_FRAME_WIDTH, frame_w);
    write_reg(REG_FRAME_HEIGHT, frame_h);
    cfg_write <= 1'b0;
    send_pixels(n_pixels, restart_pct, lead_restart);
    wait_drained();
  endtask

  initial begin
    int mode, pick, span;
    bit tall_done;
    tall_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register defaults: mode off on the full-size frame
    send_pixels(2, 50, 1'b1);
    wait_drained();
    // indexed colors at their extremes, third column past the grid
    run_phase(MODE_INDEXED, 2, 1, 1, 24'hFFFFFF, 8'hFF, 3, 2, 6, 0, 1'b1);
    // direct colors with channel carries
    run_phase(MODE_DIRECT, 2, 1, 1, 24'h01FF80, 8'h81, 3, 2, 6, 0, 1'b0);
    // zero frame size behaves as a single pixel
    run_phase(MODE_DIRECT, 1, 1, 1, 24'h123456, 8'h11, 0, 0, 2, 0, 1'b0);
    // unused mode, zero count, zero rectangle width
    run_phase(MODE_UNUSED, 1, 5, 5, 24'hABCDEF, 8'h01, 4, 4, 1, 0, 1'b1);
    run_phase(MODE_INDEXED, 0, 5, 5, 24'hABCDEF, 8'h01, 4, 4, 1, 0, 1'b1);
    run_phase(MODE_INDEXED, 3, 0, 2, 24'hABCDEF, 8'h01, 4, 4, 1, 0, 1'b1);
    // widest settings, then shrink the frame under the scan position
    run_phase(MODE_INDEXED, 255, 2047, 2047, 24'hFFFFFF, 8'hFF, 2047, 2047, 3, 0, 1'b1);
    run_phase(MODE_DIRECT, 255, 2047, 2047, 24'hFFFFFF, 8'hFF, 2, 2, 3, 0, 1'b0);

    // one-pixel columns across a wide line drive the column index to its limit
    span = $urandom_range(265, 258);
    run_phase($urandom_range(1) ? MODE_DIRECT : MODE_INDEXED, 255, 1, $urandom_range(3, 1),
              $urandom_range(24'hFFFFFF), $urandom_range(255), span, 2, span + 3, 0, 1'b1);

    // random grids, mostly small frames so that frames wrap often
    while (pixels_sent < PIXEL_TARGET) begin
      pick = $urandom_range(9);
      mode = pick < 4 ? MODE_INDEXED : pick < 8 ? MODE_DIRECT :
             pick == 8 ? MODE_OFF : MODE_UNUSED;
      if (!tall_done && pixels_sent >= 500) begin
        // one-pixel rows down a tall frame drive the row index to its limit
        tall_done = 1'b1;
        span = $urandom_range(265, 258);
        run_phase($urandom_range(1) ? MODE_DIRECT : MODE_INDEXED, 255,
                  $urandom_range(2, 1), 1, $urandom_range(24'hFFFFFF),
                  $urandom_range(255), 1, span, span + 3, 0, 1'b1);
      end else if ($urandom_range(7) == 0) begin
        run_phase(mode, $urandom_range(255), $urandom_range(2047), $urandom_range(2047),
                  $urandom_range(24'hFFFFFF), $urandom_range(255), $urandom_range(2047),
                  $urandom_range(2047), $urandom_range(30, 10), 5, 1'b0);
      end else begin
        run_phase(mode, ($urandom_range(7) == 0) ? 0 : $urandom_range(5, 1),
                  $urandom_range(4), $urandom_range(4), $urandom_range(24'hFFFFFF),
                  $urandom_range(255), $urandom_range(12), $urandom_range(8),
                  $urandom_range(60, 15), 4, 1'b0);
      end
    end

    wait_drained();
    repeat (HOLD_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
